FILE: rtl/acsr_pkg.sv
// Package with the shared types and constants of the annulus chi-square residuals unit.
`timescale 1ns / 1ps
package acsr_pkg;
	localparam int CFG_W = 32;
	localparam int IDX_W = 3;
	localparam int CNT_W = 21;
	localparam int SUM_W = 64;
	localparam int RES_W = 32;

	localparam logic [IDX_W-1:0] REG_WIDTH = 3'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_INNER = 3'd2;
	localparam logic [IDX_W-1:0] REG_OUTER = 3'd3;
	localparam logic [IDX_W-1:0] REG_GAIN = 3'd4;
	localparam logic [IDX_W-1:0] REG_VIS_EN = 3'd5;
	localparam logic [IDX_W-1:0] REG_PHA_EN = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GEOM,
		ST_REGION,
		ST_VSCALE,
		ST_VPREP,
		ST_VDIV,
		ST_VSQ,
		ST_PPREP,
		ST_PDIV,
		ST_PSQ,
		ST_MEAN,
		ST_MVDIV,
		ST_MPDIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic geom;
		logic region;
		logic vscale;
		logic vprep;
		logic vsq;
		logic pprep;
		logic psq;
		logic div_start;
		logic mean_vis;
		logic mean_pha;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic counted;
		logic vis_on;
		logic pha_on;
		logic last;
		logic empty;
		logic div_busy;
		logic div_done;
	} stat_t;
endpackage

FILE: rtl/acsr_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit dividend.
`timescale 1ns / 1ps
module acsr_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [63:0] quotient
);
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;
	logic [64:0] shifted;

	assign shifted = {rem_q, quo_q[63]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;
endmodule

FILE: rtl/acsr_ctrl.sv
// Controller state machine sequencing one pixel item through the datapath.
`timescale 1ns / 1ps
module acsr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  acsr_pkg::stat_t stat,
	output acsr_pkg::cmd_t  cmd
);
	import acsr_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	// A new item may enter while the previous result still waits to be taken.
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_GEOM;
			ST_GEOM: state_d = ST_REGION;
			ST_REGION: begin
				if (stat.counted && stat.vis_on) state_d = ST_VSCALE;
				else if (stat.counted && stat.pha_on) state_d = ST_PPREP;
				else if (stat.last) state_d = ST_MEAN;
				else state_d = ST_OUT;
			end
			ST_VSCALE: state_d = ST_VPREP;
			ST_VPREP: state_d = ST_VDIV;
			ST_VDIV: if (stat.div_done) state_d = ST_VSQ;
			ST_VSQ: begin
				if (stat.pha_on) state_d = ST_PPREP;
				else if (stat.last) state_d = ST_MEAN;
				else state_d = ST_OUT;
			end
			ST_PPREP: state_d = ST_PDIV;
			ST_PDIV: if (stat.div_done) state_d = ST_PSQ;
			ST_PSQ: state_d = stat.last ? ST_MEAN : ST_OUT;
			ST_MEAN: state_d = stat.empty ? ST_OUT : ST_MVDIV;
			ST_MVDIV: if (stat.div_done) state_d = ST_MPDIV;
			ST_MPDIV: if (stat.div_done) state_d = ST_OUT;
			ST_OUT: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_GEOM: cmd.geom = 1'b1;
			ST_REGION: cmd.region = 1'b1;
			ST_VSCALE: cmd.vscale = 1'b1;
			ST_VPREP: begin
				cmd.vprep = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_VDIV: cmd.vsq = 1'b0;
			ST_VSQ: cmd.vsq = 1'b1;
			ST_PPREP: begin
				cmd.pprep = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_PDIV: cmd.psq = 1'b0;
			ST_PSQ: cmd.psq = 1'b1;
			// The sums and the count are final here, so the mean divisions can start.
			ST_MEAN: cmd.div_start = !stat.empty;
			ST_MVDIV: begin
				cmd.mean_vis = stat.div_done;
				cmd.div_start = stat.div_done;
			end
			ST_MPDIV: cmd.mean_pha = stat.div_done;
			ST_OUT: cmd.finish = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

FILE: rtl/acsr_datapath.sv
// Datapath: region test, residual scaling, shared divider, sums and result register.
`timescale 1ns / 1ps
module acsr_datapath #(
	parameter int MAX_SIDE = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  acsr_pkg::cmd_t               cmd,
	output acsr_pkg::stat_t              stat,
	input  logic                         cfg_write,
	input  logic [acsr_pkg::IDX_W-1:0]   cfg_index,
	input  logic [acsr_pkg::CFG_W-1:0]   cfg_data,
	input  logic [9:0]                   pix_x,
	input  logic [9:0]                   pix_y,
	input  logic                         masked,
	input  logic signed [31:0]           model_vis,
	input  logic signed [31:0]           meas_vis,
	input  logic [30:0]                  vis_error,
	input  logic signed [31:0]           model_phase,
	input  logic signed [31:0]           meas_phase,
	input  logic [30:0]                  phase_error,
	input  logic                         phase_error_finite,
	input  logic                         last,
	output logic                         in_region,
	output logic signed [31:0]           vis_residual,
	output logic signed [31:0]           phase_residual,
	output logic [63:0]                  mean_vis_chi2,
	output logic [63:0]                  mean_phase_chi2,
	output logic [20:0]                  point_total,
	output logic                         done_res,
	output logic                         fault
);
	import acsr_pkg::*;

	localparam logic [63:0] MAG_LIMIT = (64'd1 << (63 - FRAC_BITS)) - 64'd1;

	// Configuration registers.
	logic [10:0] width_q, height_q, inner_q, outer_q;
	logic [31:0] gain_q;
	logic        vis_en_q, pha_en_q;

	// Captured item.
	logic [9:0]         px_q, py_q;
	logic               masked_q, finite_q, last_q;
	logic signed [31:0] mvis_q, meas_vis_q, mpha_q, meas_pha_q;
	logic [30:0]        verr_q, perr_q;

	// Working registers.
	logic [21:0] dist_q;
	logic [21:0] in2_q, out2_q;
	logic        inside_q, counted_q;
	logic [63:0] scaled_q;
	logic        neg_q, dzero_q, nzero_q;
	logic signed [31:0] vres_q, pres_q;
	logic [63:0] vsum_q, psum_q, mv_q, mp_q;
	logic [20:0] cnt_q;
	logic        flt_q;

	// Result register.
	logic               o_region_q, o_last_q, o_fault_q;
	logic signed [31:0] o_vres_q, o_pres_q;
	logic [63:0]        o_mv_q, o_mp_q;
	logic [20:0]        o_cnt_q;

	logic        div_start, div_busy, div_done;
	logic [63:0] div_dividend, div_divisor, div_quo;
	logic [63:0] num_mag_d;
	logic        num_neg_d;
	logic [30:0] den_d;
	logic [63:0] mag_cl;
	logic signed [31:0] sat_res;
	logic [31:0] res_abs;
	logic [63:0] res_sq;
	logic [64:0] sum_add;
	logic [10:0] w_cl, h_cl;
	logic signed [11:0] xc, yc;

	assign w_cl = (int'(width_q) > MAX_SIDE) ? 11'(MAX_SIDE) : width_q;
	assign h_cl = (int'(height_q) > MAX_SIDE) ? 11'(MAX_SIDE) : height_q;
	assign xc = $signed({2'b00, px_q}) - $signed(12'(w_cl >> 1));
	assign yc = $signed({2'b00, py_q}) - $signed(12'(h_cl >> 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd256;
			height_q <= 11'd256;
			inner_q <= 11'd0;
			outer_q <= 11'd64;
			gain_q <= 32'd65536;
			vis_en_q <= 1'b1;
			pha_en_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WIDTH: width_q <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data[10:0];
				REG_INNER: inner_q <= cfg_data[10:0];
				REG_OUTER: outer_q <= cfg_data[10:0];
				REG_GAIN: gain_q <= cfg_data;
				REG_VIS_EN: vis_en_q <= cfg_data[0];
				REG_PHA_EN: pha_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Numerator magnitude and sign for the residual being prepared.
	always_comb begin
		logic signed [63:0] vd;
		logic [31:0]        pd;
		vd = $signed(scaled_q) - 64'(meas_vis_q);
		pd = 32'(mpha_q) - 32'(meas_pha_q);
		if (cmd.vprep) begin
			num_neg_d = vd[63];
			num_mag_d = vd[63] ? 64'(-vd) : 64'(vd);
			den_d = verr_q;
		end else begin
			num_neg_d = pd[31];
			num_mag_d = pd[31] ? 64'(33'h1_0000_0000 - {1'b0, pd}) : 64'(pd);
			den_d = perr_q;
		end
		mag_cl = (num_mag_d > MAG_LIMIT) ? MAG_LIMIT : num_mag_d;
	end

	always_comb begin
		if (dzero_q) begin
			if (nzero_q) sat_res = '0;
			else sat_res = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else if (neg_q) begin
			sat_res = (div_quo > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(div_quo[31:0]);
		end else begin
			sat_res = (div_quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
		end
	end

	assign res_abs = sat_res[31] ? 32'(-sat_res) : 32'(sat_res);
	assign res_sq = 64'(res_abs) * 64'(res_abs);
	assign sum_add = cmd.vsq ? 65'(vsum_q) + 65'(res_sq) : 65'(psum_q) + 65'(res_sq);

	assign div_start = cmd.div_start;
	always_comb begin
		if (cmd.vprep || cmd.pprep) begin
			div_dividend = mag_cl << FRAC_BITS;
			div_divisor = 64'(den_d);
		end else begin
			div_dividend = cmd.mean_vis ? psum_q : vsum_q;
			div_divisor = 64'(cnt_q);
		end
	end

	acsr_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_dividend), .divisor(div_divisor),
		.busy(div_busy), .done(div_done), .quotient(div_quo)
	);

	// Item capture and per-item work registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= pix_x;
			py_q <= pix_y;
			masked_q <= masked;
			mvis_q <= model_vis;
			meas_vis_q <= meas_vis;
			verr_q <= vis_error;
			mpha_q <= model_phase;
			meas_pha_q <= meas_phase;
			perr_q <= phase_error;
			finite_q <= phase_error_finite;
			last_q <= last;
			vres_q <= '0;
			pres_q <= '0;
			mv_q <= '0;
			mp_q <= '0;
		end
		if (cmd.geom) begin
			dist_q <= 22'(xc) * 22'(xc) + 22'(yc) * 22'(yc);
			in2_q <= 22'(inner_q) * 22'(inner_q);
			out2_q <= 22'(outer_q) * 22'(outer_q);
			inside_q <= !masked_q && ({1'b0, px_q} < w_cl) && ({1'b0, py_q} < h_cl);
		end
		if (cmd.vscale) begin
			// Sign-magnitude scaling of the model visibility by the gain.
			logic [31:0] mm;
			logic [63:0] sm;
			mm = mvis_q[31] ? 32'(-mvis_q) : 32'(mvis_q);
			sm = (64'(mm) * 64'(gain_q)) >> FRAC_BITS;
			scaled_q <= mvis_q[31] ? 64'(-sm) : sm;
		end
		if (cmd.vprep || cmd.pprep) begin
			neg_q <= num_neg_d;
			nzero_q <= (num_mag_d == 64'd0);
			dzero_q <= (den_d == 31'd0);
		end
		if (cmd.vsq) vres_q <= sat_res;
		if (cmd.psq) pres_q <= sat_res;
		if (cmd.mean_vis) mv_q <= div_quo;
		if (cmd.mean_pha) mp_q <= div_quo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counted_q <= 1'b0;
			vsum_q <= '0;
			psum_q <= '0;
			cnt_q <= '0;
			flt_q <= 1'b0;
		end else begin
			if (cmd.region) begin
				counted_q <= inside_q && dist_q >= in2_q && dist_q <= out2_q;
				if (inside_q && dist_q >= in2_q && dist_q <= out2_q && cnt_q != '1)
					cnt_q <= cnt_q + 21'd1;
			end
			if (cmd.vsq || cmd.psq) begin
				if (dzero_q) flt_q <= 1'b1;
				if (cmd.vsq) vsum_q <= sum_add[64] ? '1 : sum_add[63:0];
				else psum_q <= sum_add[64] ? '1 : sum_add[63:0];
			end
			if (cmd.finish && last_q) begin
				vsum_q <= '0;
				psum_q <= '0;
				cnt_q <= '0;
				flt_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			o_region_q <= counted_q;
			o_vres_q <= vres_q;
			o_pres_q <= pres_q;
			o_cnt_q <= cnt_q;
			o_last_q <= last_q;
			o_mv_q <= (last_q && cnt_q == '0) ? '1 : mv_q;
			o_mp_q <= (last_q && cnt_q == '0) ? '1 : mp_q;
			o_fault_q <= flt_q || (last_q && cnt_q == '0);
		end
	end

	assign stat.counted = inside_q && dist_q >= in2_q && dist_q <= out2_q;
	assign stat.vis_on = vis_en_q;
	assign stat.pha_on = pha_en_q && finite_q;
	assign stat.last = last_q;
	assign stat.empty = (cnt_q == '0) && !(stat.counted && cmd.region);
	assign stat.div_busy = div_busy;
	assign stat.div_done = div_done;

	assign in_region = o_region_q;
	assign vis_residual = o_vres_q;
	assign phase_residual = o_pres_q;
	assign mean_vis_chi2 = o_mv_q;
	assign mean_phase_chi2 = o_mp_q;
	assign point_total = o_cnt_q;
	assign done_res = o_last_q;
	assign fault = o_fault_q;
endmodule

FILE: rtl/annulus_chi_square_residuals_unit.sv
// Top level: reduced chi-square residuals over an image annulus, one pixel per item.
// After the region test, a counted pixel computes the visibility residual and then the phase
// residual (one 64-step radix-2 division each); the last item of a frame also divides out
// the two means. Items are handled one at a time, set by the single shared divider.
// Reset: asynchronous, active low; clears sums, count, fault and loads register defaults.
`timescale 1ns / 1ps
module annulus_chi_square_residuals_unit #(
	parameter int MAX_SIDE = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [acsr_pkg::IDX_W-1:0] cfg_index,
	input  logic [acsr_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [9:0]                 pix_x,
	input  logic [9:0]                 pix_y,
	input  logic                       masked,
	input  logic signed [31:0]         model_vis,
	input  logic signed [31:0]         meas_vis,
	input  logic [30:0]                vis_error,
	input  logic signed [31:0]         model_phase,
	input  logic signed [31:0]         meas_phase,
	input  logic [30:0]                phase_error,
	input  logic                       phase_error_finite,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       in_region,
	output logic signed [31:0]         vis_residual,
	output logic signed [31:0]         phase_residual,
	output logic [63:0]                mean_vis_chi2,
	output logic [63:0]                mean_phase_chi2,
	output logic [20:0]                point_total,
	output logic                       done_res,
	output logic                       fault
);
	import acsr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	acsr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	acsr_datapath #(.MAX_SIDE(MAX_SIDE), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pix_x(pix_x), .pix_y(pix_y), .masked(masked),
		.model_vis(model_vis), .meas_vis(meas_vis), .vis_error(vis_error),
		.model_phase(model_phase), .meas_phase(meas_phase), .phase_error(phase_error),
		.phase_error_finite(phase_error_finite), .last(last),
		.in_region(in_region), .vis_residual(vis_residual),
		.phase_residual(phase_residual), .mean_vis_chi2(mean_vis_chi2),
		.mean_phase_chi2(mean_phase_chi2), .point_total(point_total),
		.done_res(done_res), .fault(fault)
	);

	// An uncounted pixel never carries a nonzero residual.
	a_zero_res: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_region |-> vis_residual == 0 && phase_residual == 0)
		else $error("residual on uncounted pixel");

	// Means are only shown on the final item of a frame.
	a_mean_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> mean_vis_chi2 == 0 && mean_phase_chi2 == 0)
		else $error("mean outside last item");

	// An empty frame at its end always reports a fault.
	a_empty_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res && point_total == 0 |-> fault)
		else $error("empty frame without fault");
endmodule

FILE: test/testbench.sv
// Testbench for the annulus chi-square residuals unit: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps
module testbench;
	import acsr_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [9:0] pix_x = '0;
	logic [9:0] pix_y = '0;
	logic masked = 1'b0;
	logic signed [31:0] model_vis = '0;
	logic signed [31:0] meas_vis = '0;
	logic [30:0] vis_error = '0;
	logic signed [31:0] model_phase = '0;
	logic signed [31:0] meas_phase = '0;
	logic [30:0] phase_error = '0;
	logic phase_error_finite = 1'b0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic in_region;
	logic signed [31:0] vis_residual;
	logic signed [31:0] phase_residual;
	logic [63:0] mean_vis_chi2;
	logic [63:0] mean_phase_chi2;
	logic [20:0] point_total;
	logic done_res;
	logic fault;

	typedef struct packed {
		logic [9:0] px;
		logic [9:0] py;
		logic msk;
		logic [31:0] mvis;
		logic [31:0] svis;
		logic [30:0] verr;
		logic [31:0] mpha;
		logic [31:0] spha;
		logic [30:0] perr;
		logic fin;
		logic lst;
	} pixel_t;

	typedef struct packed {
		logic region;
		logic [31:0] vres;
		logic [31:0] pres;
		logic [63:0] mv;
		logic [63:0] mp;
		logic [20:0] total;
		logic done;
		logic flt;
	} residual_t;

	always #2 clk = ~clk;

	annulus_chi_square_residuals_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .pix_x(pix_x),
		.pix_y(pix_y), .masked(masked), .model_vis(model_vis), .meas_vis(meas_vis),
		.vis_error(vis_error), .model_phase(model_phase), .meas_phase(meas_phase),
		.phase_error(phase_error), .phase_error_finite(phase_error_finite), .last(last),
		.out_valid(out_valid), .out_ready(out_ready), .in_region(in_region),
		.vis_residual(vis_residual), .phase_residual(phase_residual),
		.mean_vis_chi2(mean_vis_chi2), .mean_phase_chi2(mean_phase_chi2),
		.point_total(point_total), .done_res(done_res), .fault(fault)
	);

	// Shadow registers and accumulators of the predictor.
	logic [10:0] width_r, height_r, inner_r, outer_r;
	logic [31:0] gain_r;
	logic vis_on_r, pha_on_r;
	logic [63:0] vis_sum, pha_sum;
	logic [20:0] pixel_count;
	logic frame_fault;

	residual_t expected_q[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit timed_out = 1'b0;
	bit hold_off = 1'b0;
	int sent_in_frame = 0;

	function automatic logic [31:0] divide_residual(logic [63:0] mag, logic neg,
			logic [30:0] den, ref logic flt);
		logic [63:0] q;
		logic [63:0] lim;
		lim = (64'd1 << (63 - 16)) - 1;
		if (den == 0) begin
			flt = 1'b1;
			if (mag == 0) return 32'd0;
			return neg ? 32'h8000_0000 : 32'h7fff_ffff;
		end
		if (mag > lim) mag = lim;
		q = (mag << 16) / den;
		if (neg) return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
		return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
	endfunction

	function automatic logic [63:0] add_saturated(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = a + b;
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [63:0] squared(logic [31:0] r);
		logic [63:0] m;
		m = r[31] ? 64'(-$signed({32'hffff_ffff, r})) : {32'd0, r};
		return m * m;
	endfunction

	function automatic residual_t predict_residuals(pixel_t p);
		residual_t r;
		logic [10:0] w, h;
		longint xc, yc;
		logic [63:0] sq_dist, mm, sm, dm, d;
		longint m, scaled, dv;
		logic flt;
		flt = 1'b0;
		r = '0;
		w = (width_r > 1024) ? 11'd1024 : width_r;
		h = (height_r > 1024) ? 11'd1024 : height_r;
		if (!p.msk && p.px < w && p.py < h) begin
			xc = longint'(p.px) - longint'(w / 2);
			yc = longint'(p.py) - longint'(h / 2);
			sq_dist = xc * xc + yc * yc;
			r.region = sq_dist >= 64'(inner_r) * inner_r && sq_dist <= 64'(outer_r) * outer_r;
		end
		if (r.region) begin
			if (vis_on_r) begin
				m = longint'($signed(p.mvis));
				mm = (m < 0) ? -m : m;
				sm = (mm * gain_r) >> 16;
				scaled = (m < 0) ? -longint'(sm) : longint'(sm);
				dv = scaled - longint'($signed(p.svis));
				dm = (dv < 0) ? -dv : dv;
				r.vres = divide_residual(dm, dv < 0, p.verr, flt);
				vis_sum = add_saturated(vis_sum, squared(r.vres));
			end
			if (pha_on_r && p.fin) begin
				d = {32'd0, p.mpha - p.spha};
				dm = d[31] ? 64'h1_0000_0000 - d : d;
				r.pres = divide_residual(dm, d[31], p.perr, flt);
				pha_sum = add_saturated(pha_sum, squared(r.pres));
			end
			if (pixel_count != '1) pixel_count++;
		end
		if (flt) frame_fault = 1'b1;
		if (p.lst) begin
			if (pixel_count == 0) begin
				frame_fault = 1'b1;
				r.mv = '1;
				r.mp = '1;
			end else begin
				r.mv = vis_sum / pixel_count;
				r.mp = pha_sum / pixel_count;
			end
		end
		r.total = pixel_count;
		r.done = p.lst;
		r.flt = frame_fault;
		if (p.lst) begin
			vis_sum = '0;
			pha_sum = '0;
			pixel_count = '0;
			frame_fault = 1'b0;
		end
		return r;
	endfunction

	task automatic write_register(logic [IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_WIDTH: width_r = val[10:0];
			REG_HEIGHT: height_r = val[10:0];
			REG_INNER: inner_r = val[10:0];
			REG_OUTER: outer_r = val[10:0];
			REG_GAIN: gain_r = val;
			REG_VIS_EN: vis_on_r = val[0];
			REG_PHA_EN: pha_on_r = val[0];
			default: ;
		endcase
	endtask

	// Waits until every expected result has come back, then lets the block settle.
	task automatic wait_idle();
		while (expected_q.size() != 0 && !timed_out) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_pixel(pixel_t p);
		@(posedge clk);
		in_valid <= 1'b1;
		{pix_x, pix_y, masked, model_vis, meas_vis, vis_error, model_phase, meas_phase,
			phase_error, phase_error_finite, last} <= p;
		expected_q.push_back(predict_residuals(p));
		do @(posedge clk); while (!in_ready);
		in_valid <= 1'b0;
		sent_in_frame++;
	endtask

	task automatic send_with_gap(pixel_t p, bit gaps);
		send_pixel(p);
		if (gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(posedge clk);
	endtask

	function automatic pixel_t random_pixel(logic [10:0] reach);
		pixel_t p;
		logic [255:0] noise;
		int cx, cy;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom};
		p = noise[$bits(pixel_t)-1:0];
		cx = width_r > 1024 ? 512 : width_r / 2;
		cy = height_r > 1024 ? 512 : height_r / 2;
		// Most pixels land near the centre so that the annulus is hit often.
		if ($urandom_range(0, 3) != 0) begin
			p.px = 10'(cx + $urandom_range(0, 2 * reach) - reach);
			p.py = 10'(cy + $urandom_range(0, 2 * reach) - reach);
		end
		p.msk = ($urandom_range(0, 7) == 0);
		p.fin = ($urandom_range(0, 9) != 0);
		case ($urandom_range(0, 5))
			0: p.verr = 31'($urandom_range(0, 3));
			1: p.verr = 31'($urandom_range(1, 65536));
			default: ;
		endcase
		case ($urandom_range(0, 5))
			0: p.perr = 31'($urandom_range(0, 3));
			1: p.perr = 31'($urandom) >> $urandom_range(0, 30);
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0) p.mvis = 32'($signed(p.mvis) >>> $urandom_range(0, 31));
		p.lst = 1'b0;
		return p;
	endfunction

	task automatic send_frame(int n, logic [10:0] reach);
		pixel_t p;
		for (int i = 0; i < n; i++) begin
			p = random_pixel(reach);
			p.lst = (i == n - 1);
			send_with_gap(p, 1'b1);
		end
	endtask

	task automatic test_directed();
		pixel_t p;
		p = '0;
		p.px = 128; p.py = 128; p.mvis = 32'h0001_0000; p.svis = 32'h0000_8000;
		p.verr = 31'h0001_0000; p.mpha = 32'h7fff_ffff; p.spha = 32'h8000_0000;
		p.perr = 31'h0000_1000; p.fin = 1'b1;
		send_pixel(p);
		p.verr = 0; p.perr = 0;
		send_pixel(p);
		p.mvis = 32'h8000_0000; p.svis = 32'h7fff_ffff; p.verr = 31'h7fff_ffff;
		p.mpha = 32'h8000_0000; p.spha = 32'h7fff_ffff; p.perr = 1;
		send_pixel(p);
		p.mvis = 32'h7fff_ffff; p.svis = 32'h8000_0000; p.verr = 1;
		p.mpha = 32'h0; p.spha = 32'h0; p.perr = 0;
		send_pixel(p);
		p.fin = 1'b0; p.perr = 31'h7fff_ffff;
		send_pixel(p);
		p.msk = 1'b1;
		send_pixel(p);
		p.msk = 1'b0; p.px = 1023; p.py = 1023;
		send_pixel(p);
		p.px = 0; p.py = 0; p.lst = 1'b1;
		send_pixel(p);
		// An empty frame raises the fault.
		send_pixel(p);
		p.px = 128; p.py = 192; p.lst = 1'b0; p.fin = 1'b1;
		send_pixel(p);
		p.py = 193; p.lst = 1'b1;
		send_pixel(p);
		wait_idle();
	endtask

	task automatic test_geometry_settings();
		write_register(REG_WIDTH, 32'd1);
		write_register(REG_HEIGHT, 32'd1);
		write_register(REG_INNER, 32'd0);
		write_register(REG_OUTER, 32'd0);
		send_frame(6, 2);
		wait_idle();
		write_register(REG_WIDTH, 32'd2047);
		write_register(REG_HEIGHT, 32'd1024);
		write_register(REG_INNER, 32'd1024);
		write_register(REG_OUTER, 32'd2047);
		send_frame(10, 600);
		wait_idle();
		write_register(REG_INNER, 32'd20);
		write_register(REG_OUTER, 32'd40);
		write_register(REG_GAIN, 32'hffff_ffff);
		write_register(REG_VIS_EN, 32'd0);
		send_frame(20, 45);
		wait_idle();
		write_register(REG_GAIN, 32'd1);
		write_register(REG_VIS_EN, 32'd1);
		write_register(REG_PHA_EN, 32'd0);
		send_frame(20, 45);
		wait_idle();
		write_register(REG_PHA_EN, 32'd1);
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			send_frame(8, 30);
		join
		wait_idle();
	endtask

	task automatic test_random_frames();
		int sent;
		sent = 0;
		while (sent < 1800) begin
			write_register(REG_WIDTH, $urandom_range(1, 1100));
			write_register(REG_HEIGHT, $urandom_range(1, 1100));
			write_register(REG_INNER, $urandom_range(0, 30));
			write_register(REG_OUTER, $urandom_range(10, 120));
			write_register(REG_GAIN, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1 << 18));
			write_register(REG_VIS_EN, $urandom_range(0, 5) != 0);
			write_register(REG_PHA_EN, $urandom_range(0, 5) != 0);
			for (int f = 0; f < 5; f++) begin
				send_frame($urandom_range(1, 60), 11'($urandom_range(1, 130)));
				sent += sent_in_frame;
				sent_in_frame = 0;
			end
			wait_idle();
		end
	endtask

	// Receiver stall pattern, overridden by the long hold-off.
	always @(posedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(0, 9) < 7) || (($urandom & 32'hff) == 0);
	end

	always @(posedge clk) begin
		residual_t exp_r, got;
		if (arst_n && out_valid && out_ready) begin
			got = {in_region, vis_residual, phase_residual, mean_vis_chi2, mean_phase_chi2,
				point_total, done_res, fault};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result item: %p", got);
			end else begin
				exp_r = expected_q.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp_r, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			timed_out = 1'b1;
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		width_r = 256; height_r = 256; inner_r = 0; outer_r = 64;
		gain_r = 65536; vis_on_r = 1'b1; pha_on_r = 1'b1;
		vis_sum = '0; pha_sum = '0; pixel_count = '0; frame_fault = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_geometry_settings();
		test_backpressure();
		test_random_frames();
		wait_idle();
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

FILE: files.f
rtl/acsr_pkg.sv
rtl/acsr_divider.sv
rtl/acsr_ctrl.sv
rtl/acsr_datapath.sv
rtl/annulus_chi_square_residuals_unit.sv
test/testbench.sv
